>>> hw/rtl/u8u16_pkg.sv
// u8u16_pkg: shared types and constants for the utf-8 to utf-16 decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register byte addresses
    localparam logic [ADDR_W-1:0] REG_MAX_UNITS = 3'd0;

    localparam logic [15:0] MAX_UNITS_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        CAUSE_EXHAUSTED = 2'd0,
        CAUSE_ZERO      = 2'd1,
        CAUSE_STRAY     = 2'd2,
        CAUSE_LIMIT     = 2'd3
    } t_cause;

    // decoder state carried between bytes
    typedef struct packed {
        logic [2:0]  pending;
        logic        skipping;
        logic [15:0] partial;
        logic [15:0] count;
        logic        done;
    } t_state;

    // one result beat
    typedef struct packed {
        logic        unit_valid;
        logic [15:0] code_unit;
        logic        ended;
        t_cause      end_cause;
        logic [15:0] unit_count;
    } t_result;

endpackage : u8u16_pkg

`default_nettype wire

>>> hw/rtl/u8u16_cfg_regs.sv
// u8u16_cfg_regs: apb register file holding the unit limit
// depends on u8u16_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8u16_cfg_regs
    import u8u16_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output logic      [15:0]       o_max_units
);

    logic [15:0] r_max_units;
    logic        wr_en;

    assign pready = 1'b1;
    // register index is the byte address over four
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:2] == REG_MAX_UNITS[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MAX_UNITS_RESET;
        end else if (wr_en) begin
            r_max_units <= pwdata[15:0];
        end
    end

    always_comb begin
        if (paddr[ADDR_W-1:2] == REG_MAX_UNITS[ADDR_W-1:2]) begin
            prdata = {{(DATA_W-16){1'b0}}, r_max_units};
        end else begin
            prdata = '0;
        end
    end

    assign o_max_units = r_max_units;

endmodule : u8u16_cfg_regs

`default_nettype wire

>>> hw/rtl/u8u16_step.sv
// u8u16_step: combinational decode of one byte against the current state
// depends on u8u16_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8u16_step
    import u8u16_pkg::*;
(
    input  wire t_state       i_state,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_final,
    input  wire logic [15:0]  i_max_units,
    output t_state            o_state,
    output t_result           o_result,
    output logic              o_has_result
);

    t_state      n_state;
    logic        emit;
    logic        ended;
    t_cause      cause;
    logic [15:0] unit;
    logic [15:0] cnt_next;

    always_comb begin
        n_state  = i_state;
        emit     = 1'b0;
        ended    = 1'b0;
        cause    = CAUSE_EXHAUSTED;
        unit     = '0;
        cnt_next = i_state.count;

        if (i_state.done) begin
            if (i_final) begin
                n_state = '0;
            end
        end else begin
            if (i_state.pending != 3'd0) begin
                n_state.pending = i_state.pending - 3'd1;
                if (!i_state.skipping) begin
                    n_state.partial = {i_state.partial[9:0], i_byte[5:0]};
                    if (i_state.pending == 3'd1) begin
                        emit = 1'b1;
                        unit = n_state.partial;
                    end
                end else if (i_state.pending == 3'd1) begin
                    n_state.skipping = 1'b0;
                end
            end else if (i_state.count >= i_max_units) begin
                ended = 1'b1;
                cause = CAUSE_LIMIT;
            end else begin
                case (i_byte) inside
                    8'h00: begin
                        ended = 1'b1;
                        cause = CAUSE_ZERO;
                    end
                    [8'h01:8'h7F]: begin
                        emit = 1'b1;
                        unit = {8'h00, i_byte};
                    end
                    [8'h80:8'hBF]: begin
                        ended = 1'b1;
                        cause = CAUSE_STRAY;
                    end
                    [8'hC0:8'hDF]: begin
                        n_state.partial = {11'd0, i_byte[4:0]};
                        n_state.pending = 3'd1;
                    end
                    [8'hE0:8'hEF]: begin
                        n_state.partial = {12'd0, i_byte[3:0]};
                        n_state.pending = 3'd2;
                    end
                    [8'hF0:8'hF7]: begin
                        n_state.skipping = 1'b1;
                        n_state.pending  = 3'd3;
                    end
                    [8'hF8:8'hFB]: begin
                        n_state.skipping = 1'b1;
                        n_state.pending  = 3'd4;
                    end
                    default: begin
                        n_state.skipping = 1'b1;
                        n_state.pending  = 3'd5;
                    end
                endcase
            end

            if (emit) begin
                cnt_next      = i_state.count + 16'd1;
                n_state.count = cnt_next;
                if (cnt_next >= i_max_units) begin
                    ended = 1'b1;
                    cause = CAUSE_LIMIT;
                end
            end
            if (i_final && !ended) begin
                ended = 1'b1;
                cause = CAUSE_EXHAUSTED;
            end

            // final byte always rearms; an early end waits for it
            if (i_final) begin
                n_state = '0;
            end else if (ended) begin
                n_state.done = 1'b1;
            end
        end
    end

    always_comb begin
        o_state             = n_state;
        o_result.unit_valid = emit;
        o_result.code_unit  = unit;
        o_result.ended      = ended;
        o_result.end_cause  = cause;
        o_result.unit_count = cnt_next;
        o_has_result        = emit || ended;
    end

endmodule : u8u16_step

`default_nettype wire

>>> hw/rtl/utf8_to_utf16_decoder_core.sv
// utf8_to_utf16_decoder_core: top level of the utf-8 to 16-bit code unit decoder
// depends on u8u16_pkg, u8u16_cfg_regs, u8u16_step
//
// usage:
//   input channel (i_in_valid / o_in_stall) takes one string byte per beat,
//   with i_final_byte set on the last byte of each string.
//   output channel (o_out_valid / i_out_stall) gives at most one result beat
//   per byte: a decoded code unit, an end of string, or both.
//   bytes that give no result (lead and middle bytes of multi-byte forms,
//   bytes after an end) produce no output beat.
//   the apb port holds max_units at byte address 0; write it only while idle.
// timing:
//   the byte is held in the input register, decoded combinationally, and the
//   result is registered in the output register until the receiver takes it.
//   one byte per cycle sustained while the output is not stalled, set by the
//   single decode pass between the input and output registers.
// reset and stall:
//   reset empties both registers, clears the decode state and sets
//   max_units to 65535. while the output beat is stalled an occupied input
//   register holds and raises o_in_stall; an empty one still takes a byte.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder_core
    import u8u16_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // apb configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // byte input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_final_byte,
    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_unit_valid,
    output logic      [15:0]       o_code_unit,
    output logic                   o_ended,
    output logic      [1:0]        o_end_cause,
    output logic      [15:0]       o_unit_count
);

    logic [15:0] max_units;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_final;

    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    logic        n_has_result;

    logic        r_out_valid;
    t_result     r_out;

    logic        out_hold;

    u8u16_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_units (max_units)
    );

    u8u16_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_final      (r_in_final),
        .i_max_units  (max_units),
        .o_state      (n_state),
        .o_result     (n_result),
        .o_has_result (n_has_result)
    );

    // output slot busy with a beat the receiver has not taken
    assign out_hold   = r_out_valid && i_out_stall;
    assign o_in_stall = r_in_valid && out_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_in_byte;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (!out_hold) begin
            r_out_valid <= r_in_valid && n_has_result;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_hold && r_in_valid) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_unit_valid = r_out.unit_valid;
    assign o_code_unit  = r_out.code_unit;
    assign o_ended      = r_out.ended;
    assign o_end_cause  = r_out.end_cause;
    assign o_unit_count = r_out.unit_count;

    // every result beat carries a unit or an end
    a_beat_has_content: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_unit_valid || o_ended)
    ) else $error("result beat with neither unit nor end");

    // an end-only beat carries a zero code unit
    a_no_unit_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_unit_valid) |-> (o_code_unit == 16'd0)
    ) else $error("code unit not zero on end-only beat");

    // cause stays zero unless the beat ends the string
    a_cause_only_on_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ended) |-> (o_end_cause == CAUSE_EXHAUSTED)
    ) else $error("end cause set without end");

    // a string that has ended carries no pending form
    a_done_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_state.done |-> (r_state.pending == 3'd0)
    ) else $error("ended string still holds a pending form");

endmodule : utf8_to_utf16_decoder_core

`default_nettype wire
